/* rtl/fir_filter_q16_round_defines.svh */
// Assertion macros shared by the checker of the FIR filter block.
// Depends on nothing; every user supplies clock and reset signals named clock and reset.
`ifndef FIR_FILTER_Q16_ROUND_DEFINES_SVH
`define FIR_FILTER_Q16_ROUND_DEFINES_SVH

// Next-cycle implication, switched off while reset is high.
`define FIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("FIR filter assertion failed");

// Next-cycle implication that also holds across reset.
`define FIR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("FIR filter reset assertion failed");

`endif

/* rtl/fir_q16_pkg.sv */
// Shared types, constants and the demo kernel for the FIR filter block.
// Depends on nothing; used by the sequencer, the multiply-accumulate unit and the top level.
package fir_q16_pkg;

   // Default tap count and fixed field widths.
   localparam int FIR_TAPS   = 32;
   localparam int DATA_W     = 16;
   localparam int ACC_W      = 32;
   localparam int KERNEL_LEN = 32;
   localparam int KERNEL_AW  = 5;

   // Rounding bias added before the final shift.
   localparam logic [ACC_W-1:0] ROUND_BIAS = 32'h0000_8000;

   // Item mode codes.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   // Coefficient values loaded after reset; the entry 'o70 is octal.
   localparam logic [DATA_W-1:0] DEMO_KERNEL [KERNEL_LEN] = '{
      16'h0010, 16'h0020, 16'h0040, 16'h0070, 16'h008c, 16'h00a2, 16'h00ce, 16'h00f0,
      16'h00e9, 16'h00ce, 16'h00a2, 16'h008c, 16'o70,   16'h0040, 16'h0020, 16'h0010,
      16'h0010, 16'h0020, 16'h0040, 16'h0070, 16'h008c, 16'h00a2, 16'h00ce, 16'h00f0,
      16'h00e9, 16'h00ce, 16'h00a2, 16'h008c, 16'o70,   16'h0040, 16'h0020, 16'h0010
   };

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic init_we;
      logic smp_we;
      logic coef_we;
      logic clear;
      logic issue;
      logic load_out;
   } ctrl_type;

endpackage

/* rtl/fir_q16_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
// Depends on nothing; used for the delay line and the coefficient store.
module fir_q16_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read share the clock; a read returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fir_q16_mac.sv */
// Shared multiply-accumulate unit with final rounding of the sum.
// Depends on fir_q16_pkg for widths, the rounding bias and the control word.
module fir_q16_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fir_q16_pkg::ctrl_type                 ctl,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] dl_data,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] cf_data,
   output logic                                  busy,
   output logic signed [fir_q16_pkg::DATA_W-1:0] result
);

   localparam int AccW  = fir_q16_pkg::ACC_W;
   localparam int DataW = fir_q16_pkg::DATA_W;

   logic                   data_vld_ff;
   logic                   prod_vld_ff;
   logic signed [AccW-1:0] prod_ff;
   logic [AccW-1:0]        acc_ff;
   logic [AccW-1:0]        acc_in;
   logic [AccW-1:0]        rounded;

   // Valid flags follow the memory read latency and then the multiply stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         data_vld_ff <= ctl.issue;
         prod_vld_ff <= data_vld_ff;
      end
   end

   // Product register between the multiplier and the adder.
   always_ff @(posedge clock) begin
      if (data_vld_ff) begin
         prod_ff <= dl_data * cf_data;
      end
   end

   // The accumulator wraps modulo 2^32.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + AccW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round to nearest and keep the upper half of the word.
   assign rounded = acc_ff + fir_q16_pkg::ROUND_BIAS;
   assign result  = rounded[AccW-1:AccW-DataW];
   assign busy    = data_vld_ff | prod_vld_ff;

endmodule

/* rtl/fir_q16_ctrl.sv */
// Sequencer of the FIR filter: memory fill after reset, tap walk and result hand-off.
// Depends on fir_q16_pkg for the state type, mode codes and control word.
module fir_q16_ctrl #(
   parameter int TAPS = fir_q16_pkg::FIR_TAPS,
   localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   input  logic [4:0]            req_coef_index,
   input  logic                  out_free,
   input  logic                  mac_busy,
   output logic                  req_ready,
   output fir_q16_pkg::ctrl_type ctl,
   output logic [AW-1:0]         dl_waddr,
   output logic [AW-1:0]         dl_raddr,
   output logic [AW-1:0]         cf_waddr,
   output logic [AW-1:0]         cf_raddr
);

   localparam int IW = (AW > 5) ? AW : 5;
   localparam logic [AW-1:0] LastIdx = AW'(TAPS - 1);

   fir_q16_pkg::state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_next;
   logic [AW-1:0] rd_ptr_next;
   logic [AW-1:0] cnt_next;
   logic [IW-1:0] idx_ext;
   logic          idx_ok;
   logic          take_sample;
   logic          take_coef;

   // Wrapping increments of the counters and pointers.
   assign wr_ptr_next = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
   assign cnt_next    = (cnt_ff == LastIdx) ? '0 : cnt_ff + 1'b1;

   // Coefficient writes beyond the tap count are dropped.
   assign idx_ext = IW'(req_coef_index);
   assign idx_ok  = (32'(req_coef_index) < TAPS);

   assign take_sample = (state_ff == fir_q16_pkg::ST_IDLE) && req_valid &&
                        (req_mode == fir_q16_pkg::MODE_SAMPLE);
   assign take_coef   = (state_ff == fir_q16_pkg::ST_IDLE) && req_valid &&
                        (req_mode == fir_q16_pkg::MODE_COEF);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fir_q16_pkg::ST_INIT: begin
            if (cnt_ff == LastIdx) state_in = fir_q16_pkg::ST_IDLE;
         end
         fir_q16_pkg::ST_IDLE: begin
            if (take_sample) state_in = fir_q16_pkg::ST_READ;
         end
         fir_q16_pkg::ST_READ: begin
            if (cnt_ff == LastIdx) state_in = fir_q16_pkg::ST_DRAIN;
         end
         fir_q16_pkg::ST_DRAIN: begin
            if (!mac_busy) state_in = fir_q16_pkg::ST_OUT;
         end
         fir_q16_pkg::ST_OUT: begin
            if (out_free) state_in = fir_q16_pkg::ST_IDLE;
         end
         default: state_in = fir_q16_pkg::ST_INIT;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fir_q16_pkg::ST_INIT: begin
            ctl.init_we = 1'b1;
         end
         fir_q16_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.smp_we  = take_sample;
            ctl.clear   = take_sample;
            ctl.coef_we = take_coef && idx_ok;
         end
         fir_q16_pkg::ST_READ: begin
            ctl.issue = 1'b1;
         end
         fir_q16_pkg::ST_DRAIN: begin
            ctl = '0;
         end
         fir_q16_pkg::ST_OUT: begin
            ctl.load_out = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // Counter and pointer updates.
   always_comb begin
      cnt_in    = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      case (state_ff)
         fir_q16_pkg::ST_INIT: begin
            cnt_in    = cnt_next;
            wr_ptr_in = '0;
         end
         fir_q16_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (take_sample) begin
               wr_ptr_in = wr_ptr_next;
               rd_ptr_in = wr_ptr_next;
            end
         end
         fir_q16_pkg::ST_READ: begin
            cnt_in    = cnt_next;
            rd_ptr_in = rd_ptr_next;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fir_q16_pkg::ST_INIT;
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Memory addresses: the fill pass uses the counter for both stores.
   assign dl_waddr = (state_ff == fir_q16_pkg::ST_INIT) ? cnt_ff : wr_ptr_ff;
   assign cf_waddr = (state_ff == fir_q16_pkg::ST_INIT) ? cnt_ff : idx_ext[AW-1:0];
   assign dl_raddr = rd_ptr_ff;
   assign cf_raddr = cnt_ff;

endmodule

/* rtl/fir_filter_q16_round.sv */
// Top level of the streaming FIR filter with rounded Q16 output.
// Depends on fir_q16_pkg, fir_q16_ram, fir_q16_mac and fir_q16_ctrl.
//
// Usage:
//  - Input channel req_*: one word per item. req_mode 0 pushes req_sample into the
//    delay line and yields one word on rsp_filtered; req_mode 1 writes req_coef_value
//    to tap req_coef_index and yields nothing (indexes at or beyond TAPS are dropped).
//  - Result channel rsp_*: valid/ready; the result sits in an output register and
//    holds until taken while the block already accepts the next word.
//  - A sample passes from acceptance through a read state in which the single
//    multiply-accumulate unit walks the taps, a drain state that empties its read and
//    multiply stages, and an output state that loads the rounded sum for output.
//    req_ready is low for that time, so a new sample is accepted only after the last
//    result is loaded; a coefficient write leaves the block ready for the next word.
//  - After reset the block fills the delay line with zero and the coefficient
//    store with the demo kernel; req_ready stays low meanwhile.
//  - If the receiver stalls, a finished result waits in the output state until the
//    output register frees, and no further word is accepted until then.
module fir_filter_q16_round #(
   parameter int TAPS = fir_q16_pkg::FIR_TAPS,
   localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] req_sample,
   input  logic [4:0]                            req_coef_index,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] req_coef_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fir_q16_pkg::DATA_W-1:0] rsp_filtered
);

   localparam int DataW = fir_q16_pkg::DATA_W;
   localparam int KAW   = fir_q16_pkg::KERNEL_AW;

   fir_q16_pkg::ctrl_type ctl;
   logic [AW-1:0]          dl_waddr, dl_raddr, cf_waddr, cf_raddr;
   logic [DataW-1:0]       dl_wdata, cf_wdata;
   logic [DataW-1:0]       dl_rdata, cf_rdata;
   logic [KAW-1:0]         kern_idx;
   logic                   dl_we, cf_we;
   logic                   out_free;
   logic                   mac_busy;
   logic signed [DataW-1:0] mac_result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] rsp_filtered_ff;

   // Output register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   fir_q16_ctrl #(.TAPS(TAPS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_mode       (req_mode),
      .req_coef_index (req_coef_index),
      .out_free       (out_free),
      .mac_busy       (mac_busy),
      .req_ready      (req_ready),
      .ctl            (ctl),
      .dl_waddr       (dl_waddr),
      .dl_raddr       (dl_raddr),
      .cf_waddr       (cf_waddr),
      .cf_raddr       (cf_raddr)
   );

   // Write data: reset values during the fill pass, item fields otherwise.
   assign kern_idx = KAW'(cf_waddr);
   assign dl_wdata = ctl.init_we ? '0 : req_sample;
   assign cf_wdata = ctl.init_we ? fir_q16_pkg::DEMO_KERNEL[kern_idx] : req_coef_value;
   assign dl_we    = ctl.init_we | ctl.smp_we;
   assign cf_we    = ctl.init_we | ctl.coef_we;

   fir_q16_ram #(.DEPTH(TAPS), .WIDTH(DataW)) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   fir_q16_ram #(.DEPTH(TAPS), .WIDTH(DataW)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cf_we),
      .wr_addr (cf_waddr),
      .wr_data (cf_wdata),
      .rd_addr (cf_raddr),
      .rd_data (cf_rdata)
   );

   fir_q16_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .dl_data (dl_rdata),
      .cf_data (cf_rdata),
      .busy    (mac_busy),
      .result  (mac_result)
   );

   // Result word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_filtered_ff <= mac_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

endmodule

/* rtl/fir_q16_checker.sv */
// Port-level checker of the FIR filter and its bind to the top level.
// Depends on fir_filter_q16_round_defines.svh for the assertion macros.
`include "fir_filter_q16_round_defines.svh"

module fir_q16_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_filtered
);

   // A stalled result word holds its value.
   `FIR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered))

   // A sample word keeps the block busy in the following cycle.
   `FIR_ASSERT_NEXT(a_sample_busy, req_valid && req_ready && !req_mode, !req_ready)

   // A coefficient word never produces a result.
   `FIR_ASSERT_NEXT(a_coef_silent, req_valid && req_ready && req_mode && !rsp_valid, !rsp_valid)

   // Reset empties the output and starts the memory fill.
   `FIR_ASSERT_NEXT_ALWAYS(a_reset_state, reset, !rsp_valid && !req_ready)

endmodule

bind fir_filter_q16_round fir_q16_checker u_checker (.*);

/* verif/fir_filter_q16_round_checker.sv */
// Checker for the streaming FIR filter: watches both channels, predicts each filtered word
// and compares it with the word the block delivers. Depends on fir_q16_pkg only.
`timescale 1ns / 100ps

module fir_filter_q16_round_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] req_sample,
   input  logic [4:0]                            req_coef_index,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] req_coef_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [fir_q16_pkg::DATA_W-1:0] rsp_filtered,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    sample_count,
   output int                                    coef_count,
   output int                                    checked_count
);
   import fir_q16_pkg::*;

   // Coefficients after reset: a 16-entry kernel repeated twice.
   // The entry 16'h0038 is the octal 70 of the original table.
   localparam logic signed [15:0] KERNEL_INIT [32] = '{
      16'h0010, 16'h0020, 16'h0040, 16'h0070, 16'h008c, 16'h00a2, 16'h00ce, 16'h00f0,
      16'h00e9, 16'h00ce, 16'h00a2, 16'h008c, 16'h0038, 16'h0040, 16'h0020, 16'h0010,
      16'h0010, 16'h0020, 16'h0040, 16'h0070, 16'h008c, 16'h00a2, 16'h00ce, 16'h00f0,
      16'h00e9, 16'h00ce, 16'h00a2, 16'h008c, 16'h0038, 16'h0040, 16'h0020, 16'h0010
   };

   // Private copy of the filter state; index 0 holds the oldest sample.
   logic signed [15:0] tap_history [FIR_TAPS];
   logic signed [15:0] coef_bank   [FIR_TAPS];
   logic signed [15:0] filtered_expected [$];

   // Sum of products in a wrapping 32-bit accumulator, rounded, top half kept.
   function automatic logic signed [15:0] predict_filtered();
      logic        [31:0] acc;
      logic signed [31:0] prod;
      acc = '0;
      for (int j = 0; j < FIR_TAPS; j++) begin
         prod = coef_bank[j] * tap_history[j];
         acc  = acc + prod;
      end
      acc = acc + 32'h0000_8000;
      return acc[31:16];
   endfunction

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         for (int j = 0; j < FIR_TAPS; j++) begin
            tap_history[j] = '0;
            coef_bank[j]   = KERNEL_INIT[j % 32];
         end
         filtered_expected.delete();
         fail_count    = 0;
         pending_count = 0;
         sample_count  = 0;
         coef_count    = 0;
         checked_count = 0;
      end else begin
         // Result word: compare against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (filtered_expected.size() == 0) begin
               $error("filtered: no word expected, got %0d", rsp_filtered);
               fail_count = fail_count + 1;
            end else begin
               want = filtered_expected.pop_front();
               if (rsp_filtered !== want) begin
                  $error("filtered: expected %0d, actual %0d", want, rsp_filtered);
                  fail_count = fail_count + 1;
               end
               checked_count = checked_count + 1;
            end
         end
         // Request word: shift a sample in and predict, or update one coefficient.
         if (req_valid && req_ready) begin
            if (req_mode == MODE_SAMPLE) begin
               for (int j = 0; j < FIR_TAPS - 1; j++)
                  tap_history[j] = tap_history[j+1];
               tap_history[FIR_TAPS-1] = req_sample;
               filtered_expected.push_back(predict_filtered());
               sample_count = sample_count + 1;
            end else begin
               if (int'(req_coef_index) < FIR_TAPS)
                  coef_bank[req_coef_index] = req_coef_value;
               coef_count = coef_count + 1;
            end
         end
         pending_count = filtered_expected.size();
      end
   end

endmodule

/* verif/tb.sv */
// Testbench top for the streaming FIR filter: clock, reset, request and result traffic.
// Depends on fir_q16_pkg, fir_filter_q16_round and fir_filter_q16_round_checker.
`timescale 1ns / 100ps

module tb;
   import fir_q16_pkg::*;

   localparam int RANDOM_WORDS = 1200;
   localparam int LONG_HOLD    = 400;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic signed [15:0] req_sample;
   logic [4:0]         req_coef_index;
   logic signed [15:0] req_coef_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_filtered;

   int fail_count;
   int pending_count;
   int sample_count;
   int coef_count;
   int checked_count;
   bit send_quiet;

   always #1 clock = ~clock;

   fir_filter_q16_round u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered)
   );

   fir_filter_q16_round_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .sample_count   (sample_count),
      .coef_count     (coef_count),
      .checked_count  (checked_count)
   );

   // A 16-bit value biased toward the extremes and small magnitudes.
   function automatic logic [15:0] pick_word();
      logic [31:0] r;
      int          sel;
      r   = $urandom;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return r[0] ? 16'hffff : 16'h0000;
         3, 4:    return {{8{r[7]}}, r[7:0]};
         default: return r[15:0];
      endcase
   endfunction

   // Offer one word after a random gap (none while send_quiet is set) and hold it until the block takes it.
   task automatic send_word(input logic mode, input logic [15:0] sample,
                            input logic [4:0] index, input logic [15:0] value);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_sample     <= sample;
      req_coef_index <= index;
      req_coef_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // The unused fields of each word carry random junk.
   task automatic push_sample(input logic [15:0] sample);
      send_word(MODE_SAMPLE, sample, 5'($urandom), 16'($urandom));
   endtask

   task automatic write_coef(input logic [4:0] index, input logic [15:0] value);
      send_word(MODE_COEF, 16'($urandom), index, value);
   endtask

   // Result side: random hold-off per word, quiet stretches, and one long stall.
   initial begin : receiver
      int  hold_cycles;
      int  taken;
      bit  quiet;
      rsp_ready = 1'b0;
      taken     = 0;
      quiet     = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         hold_cycles = quiet ? 0 : $urandom_range(0, 11);
         if (taken == 150) hold_cycles = LONG_HOLD;
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken = taken + 1;
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int sent;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_SAMPLE;
      req_sample     = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      send_quiet     = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Sample extremes through the reset kernel.
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'hffff);
      push_sample(16'h0001);
      // Coefficient extremes at both ends of the index range.
      write_coef(5'd0, 16'h7fff);
      write_coef(5'd31, 16'h8000);
      write_coef(5'd30, 16'h8000);
      write_coef(5'd29, 16'h8000);
      write_coef(5'd28, 16'h8000);
      // Four full-scale positive products on the newest taps wrap the accumulator.
      repeat (4) push_sample(16'h8000);
      write_coef(5'd15, 16'h0000);
      write_coef(5'd16, 16'hffff);
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h7fff);

      // Random traffic: mostly samples, single coefficient updates, and full kernel reloads.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 79) == 0) send_quiet = !send_quiet;
         if ($urandom_range(0, 39) == 0) begin
            for (int j = 0; j < 32; j++) write_coef(5'(j), pick_word());
            sent = sent + 32;
         end else begin
            if ($urandom_range(0, 3) == 0) write_coef(5'($urandom), pick_word());
            else push_sample(pick_word());
            sent = sent + 1;
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow one more filter pass of slack.
      while (pending_count != 0) @(negedge clock);
      repeat (FIR_TAPS + 8) @(negedge clock);

      $display("summary: %0d samples filtered, %0d coefficient writes, %0d words compared",
               sample_count, coef_count, checked_count);
      $display("summary: gaps of 0 to 11 cycles on both sides, one %0d-cycle result stall",
               LONG_HOLD);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin : watchdog
      #600000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
